>>> hw/rtl/mpc_pkg.sv
// shared types and constants of the mahalanobis pixel classifier
package mpc_pkg;

	// item field widths
	localparam int REQ_TYPE_W = 1;
	localparam int CLASS_W    = 5;
	localparam int PIDX_W     = 4;
	localparam int PVAL_W     = 40;
	localparam int PIX_W      = 8;
	localparam int LABEL_W    = 5;
	localparam int CFG_W      = 6;
	localparam int MEAN_W     = 16;

	// request codes
	localparam logic [REQ_TYPE_W-1:0] REQ_LOAD     = 1'b0;
	localparam logic [REQ_TYPE_W-1:0] REQ_CLASSIFY = 1'b1;

	// parameter word indexes: means first, then the 3x3 matrix row-major
	localparam logic [PIDX_W-1:0] PIDX_COV_FIRST = 4'd3;
	localparam logic [PIDX_W-1:0] PIDX_END       = 4'd12;

	// datapath widths
	localparam int D_W      = 17;   // signed 8.8 difference
	localparam int Q_W      = 34;   // product of two differences
	localparam int MUL_A_W  = 35;
	localparam int MUL_B_W  = 21;
	localparam int PROD_W   = MUL_A_W + MUL_B_W;
	localparam int ACC_W    = 80;
	localparam int HI_SHIFT = 20;   // coefficient split point

	// control of the shared multiply-accumulate unit
	typedef struct packed {
		logic mul_en;    // capture a new product
		logic acc_clr;   // start a new quadratic form
		logic lo_next;   // add the product next cycle as is
		logic hi_next;   // add the product next cycle shifted by HI_SHIFT
	} mac_ctrl_t;

endpackage

>>> hw/rtl/mpc_ifs.sv
// valid/ready channel interfaces of the mahalanobis pixel classifier

// request channel: parameter loads and pixels
interface mpc_req_if;
	logic                             valid;
	logic                             ready;
	logic [mpc_pkg::REQ_TYPE_W-1:0]   req_type;
	logic [mpc_pkg::CLASS_W-1:0]      class_index;
	logic [mpc_pkg::PIDX_W-1:0]       param_index;
	logic signed [mpc_pkg::PVAL_W-1:0] param_value;
	logic [mpc_pkg::PIX_W-1:0]        red;
	logic [mpc_pkg::PIX_W-1:0]        green;
	logic [mpc_pkg::PIX_W-1:0]        blue;

	modport source (output valid, req_type, class_index, param_index, param_value,
		red, green, blue, input ready);
	modport sink (input valid, req_type, class_index, param_index, param_value,
		red, green, blue, output ready);
endinterface

// result channel: classified pixels
interface mpc_res_if;
	logic                         valid;
	logic                         ready;
	logic [mpc_pkg::PIX_W-1:0]    out_red;
	logic [mpc_pkg::PIX_W-1:0]    out_green;
	logic [mpc_pkg::PIX_W-1:0]    out_blue;
	logic [mpc_pkg::LABEL_W-1:0]  class_label;

	modport source (output valid, out_red, out_green, out_blue, class_label, input ready);
	modport sink (input valid, out_red, out_green, out_blue, class_label, output ready);
endinterface

// configuration write channel: class count
interface mpc_cfg_if;
	logic                       valid;
	logic                       ready;
	logic [mpc_pkg::CFG_W-1:0]  num_classes;

	modport source (output valid, num_classes, input ready);
	modport sink (input valid, num_classes, output ready);
endinterface

>>> hw/rtl/mpc_mac.sv
// shared signed multiplier with product register and wide accumulator
module mpc_mac (
	input  logic                                clk,
	input  logic                                arst_n,
	input  mpc_pkg::mac_ctrl_t                  ctrl,
	input  logic signed [mpc_pkg::MUL_A_W-1:0]  a,
	input  logic signed [mpc_pkg::MUL_B_W-1:0]  b,
	output logic signed [mpc_pkg::PROD_W-1:0]   prod,
	output logic signed [mpc_pkg::ACC_W-1:0]    acc
);

	logic signed [mpc_pkg::PROD_W-1:0] prod_q;
	logic signed [mpc_pkg::ACC_W-1:0]  acc_q;
	logic signed [mpc_pkg::ACC_W-1:0]  prod_ext;
	logic signed [mpc_pkg::ACC_W-1:0]  addend;
	logic                              lo_pend_q;
	logic                              hi_pend_q;

	// product register
	always_ff @(posedge clk) begin
		if (ctrl.mul_en) begin
			prod_q <= a * b;
		end
	end

	// pending add flags, registered alongside the product
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lo_pend_q <= 1'b0;
			hi_pend_q <= 1'b0;
		end else begin
			lo_pend_q <= ctrl.lo_next;
			hi_pend_q <= ctrl.hi_next;
		end
	end

	// sign-extend and align the pending partial product
	assign prod_ext = mpc_pkg::ACC_W'(prod_q);
	assign addend   = hi_pend_q ? (prod_ext <<< mpc_pkg::HI_SHIFT) : prod_ext;

	// accumulator
	always_ff @(posedge clk) begin
		if (ctrl.acc_clr) begin
			acc_q <= '0;
		end else if (lo_pend_q || hi_pend_q) begin
			acc_q <= acc_q + addend;
		end
	end

	assign prod = prod_q;
	assign acc  = acc_q;

endmodule

>>> hw/rtl/mahalanobis_pixel_classifier.sv
// top level: parameter memories, class sequencer and best-score selection
//
//  channel | dir | handshake    | payload
//  --------+-----+--------------+---------------------------------------------------
//  req     | in  | valid/ready  | req_type, class_index, param_index, param_value, rgb
//  res     | out | valid/ready  | out_red, out_green, out_blue, class_label
//  cfg     | in  | valid/ready  | num_classes
//
// a load transfer leaves the sequencer idle, so the block stays ready for the next transfer
// a pixel takes each class through mean reads, matrix terms, a final add and a compare, then the output state;
// the one shared multiplier does three products for each of the nine matrix terms
// reset clears the sequencer and sets the class count to one; memories are not cleared
// a finished result waits in the output register while new transfers are taken;
// a second result waits until the first is taken
module mahalanobis_pixel_classifier #(
	parameter int MAX_CLASSES = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	mpc_req_if.sink     req,
	mpc_res_if.source   res,
	mpc_cfg_if.sink     cfg
);

	localparam int MEAN_DEPTH = MAX_CLASSES * 3;
	localparam int COV_DEPTH  = MAX_CLASSES * 9;
	localparam int MA_W       = $clog2(MEAN_DEPTH);
	localparam int CA_W       = $clog2(COV_DEPTH);
	localparam int CNT_W      = $clog2(MAX_CLASSES + 1);

	// sequencer states
	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_MEAN = 3'd1;
	localparam logic [2:0] S_TERM = 3'd2;
	localparam logic [2:0] S_LAST = 3'd3;
	localparam logic [2:0] S_CMP  = 3'd4;
	localparam logic [2:0] S_OUT  = 3'd5;

	// phases of one matrix term
	localparam logic [1:0] PH_DD = 2'd0;
	localparam logic [1:0] PH_LO = 2'd1;
	localparam logic [1:0] PH_HI = 2'd2;

	logic [2:0]                            state_q;
	logic [1:0]                            k_q;
	logic [1:0]                            ph_q;
	logic [1:0]                            i_q;
	logic [1:0]                            j_q;
	logic [CNT_W-1:0]                      class_q;
	logic [CNT_W-1:0]                      count_q;
	logic [CNT_W-1:0]                      count_start;
	logic [8:0]                            ncls;
	logic [MA_W-1:0]                       mean_addr_q;
	logic [CA_W-1:0]                       cov_addr_q;
	logic [mpc_pkg::CFG_W-1:0]             num_classes_q;
	logic                                  res_valid_q;
	logic                                  req_fire;
	logic                                  last_class;
	logic                                  out_free;

	logic [mpc_pkg::MEAN_W-1:0]            mean_mem [MEAN_DEPTH];
	logic [mpc_pkg::PVAL_W-1:0]            cov_mem [COV_DEPTH];
	logic [mpc_pkg::MEAN_W-1:0]            mean_rd_q;
	logic [mpc_pkg::PVAL_W-1:0]            cov_rd_q;
	logic [15:0]                           ld_mean_addr;
	logic [15:0]                           ld_cov_addr;
	logic                                  ld_ok;

	logic [mpc_pkg::PIX_W-1:0]             red_q;
	logic [mpc_pkg::PIX_W-1:0]             green_q;
	logic [mpc_pkg::PIX_W-1:0]             blue_q;
	logic [mpc_pkg::PIX_W-1:0]             pix_sel;
	logic signed [mpc_pkg::D_W-1:0]        d_new;
	logic signed [mpc_pkg::D_W-1:0]        di_q [3];
	logic signed [mpc_pkg::D_W-1:0]        dj_q [3];
	logic signed [mpc_pkg::Q_W-1:0]        q_q;

	mpc_pkg::mac_ctrl_t                    mac_ctrl;
	logic signed [mpc_pkg::MUL_A_W-1:0]    mul_a;
	logic signed [mpc_pkg::MUL_B_W-1:0]    mul_b;
	logic signed [mpc_pkg::PROD_W-1:0]     prod;
	logic signed [mpc_pkg::ACC_W-1:0]      acc;
	logic signed [mpc_pkg::ACC_W-1:0]      best_q;
	logic [CNT_W-1:0]                      best_idx_q;

	logic [mpc_pkg::PIX_W-1:0]             out_red_q;
	logic [mpc_pkg::PIX_W-1:0]             out_green_q;
	logic [mpc_pkg::PIX_W-1:0]             out_blue_q;
	logic [mpc_pkg::LABEL_W-1:0]           label_q;

	// handshakes
	assign req.ready = (state_q == S_IDLE);
	assign req_fire  = req.valid && req.ready;
	assign cfg.ready = 1'b1;
	assign out_free  = !res_valid_q || res.ready;

	// class count, zero taken as one, saturated at the memory size
	assign ncls = 9'(num_classes_q);
	always_comb begin
		if (ncls == 9'd0) begin
			count_start = CNT_W'(1);
		end else if (ncls > 9'(MAX_CLASSES)) begin
			count_start = CNT_W'(MAX_CLASSES);
		end else begin
			count_start = CNT_W'(ncls);
		end
	end

	assign last_class = (CNT_W'(class_q + 1'b1) == count_q);

	// configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_classes_q <= mpc_pkg::CFG_W'(1);
		end else if (cfg.valid && cfg.ready) begin
			num_classes_q <= cfg.num_classes;
		end
	end

	// load addressing
	assign ld_mean_addr = 16'(req.class_index) * 16'd3 + 16'(req.param_index);
	assign ld_cov_addr  = 16'(req.class_index) * 16'd9 + 16'(req.param_index)
		- 16'(mpc_pkg::PIDX_COV_FIRST);
	assign ld_ok = req_fire && (req.req_type == mpc_pkg::REQ_LOAD)
		&& (32'(req.class_index) < 32'(MAX_CLASSES));

	// mean memory
	always_ff @(posedge clk) begin
		if (ld_ok && (req.param_index < mpc_pkg::PIDX_COV_FIRST)) begin
			mean_mem[ld_mean_addr[MA_W-1:0]] <= req.param_value[mpc_pkg::MEAN_W-1:0];
		end
		if (state_q == S_MEAN && k_q != 2'd3) begin
			mean_rd_q <= mean_mem[mean_addr_q];
		end
	end

	// inverse covariance memory
	always_ff @(posedge clk) begin
		if (ld_ok && (req.param_index >= mpc_pkg::PIDX_COV_FIRST)
			&& (req.param_index < mpc_pkg::PIDX_END)) begin
			cov_mem[ld_cov_addr[CA_W-1:0]] <= req.param_value;
		end
		if (state_q == S_TERM && ph_q == PH_DD) begin
			cov_rd_q <= cov_mem[cov_addr_q];
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			k_q         <= '0;
			ph_q        <= PH_DD;
			i_q         <= '0;
			j_q         <= '0;
			class_q     <= '0;
			count_q     <= CNT_W'(1);
			mean_addr_q <= '0;
			cov_addr_q  <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (req_fire && req.req_type == mpc_pkg::REQ_CLASSIFY) begin
						state_q     <= S_MEAN;
						k_q         <= '0;
						class_q     <= '0;
						count_q     <= count_start;
						mean_addr_q <= '0;
						cov_addr_q  <= '0;
					end
				end
				S_MEAN: begin
					if (k_q != 2'd3) begin
						mean_addr_q <= MA_W'(mean_addr_q + 1'b1);
						k_q         <= k_q + 2'd1;
					end else begin
						state_q <= S_TERM;
						ph_q    <= PH_DD;
						i_q     <= '0;
						j_q     <= '0;
					end
				end
				S_TERM: begin
					case (ph_q)
						PH_DD: begin
							cov_addr_q <= CA_W'(cov_addr_q + 1'b1);
							ph_q       <= PH_LO;
						end
						PH_LO: ph_q <= PH_HI;
						default: begin
							ph_q <= PH_DD;
							if (j_q == 2'd2) begin
								j_q <= '0;
								i_q <= i_q + 2'd1;
								if (i_q == 2'd2) begin
									state_q <= S_LAST;
								end
							end else begin
								j_q <= j_q + 2'd1;
							end
						end
					endcase
				end
				S_LAST: state_q <= S_CMP;
				S_CMP: begin
					if (last_class) begin
						state_q <= S_OUT;
					end else begin
						class_q <= CNT_W'(class_q + 1'b1);
						k_q     <= '0;
						state_q <= S_MEAN;
					end
				end
				S_OUT: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// result valid: set on a finished pixel, cleared once taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (state_q == S_OUT && out_free) begin
			res_valid_q <= 1'b1;
		end else if (res.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	// pixel channel for the difference of the mean read last cycle
	always_comb begin
		case (k_q)
			2'd1:    pix_sel = red_q;
			2'd2:    pix_sel = green_q;
			default: pix_sel = blue_q;
		endcase
	end

	assign d_new = mpc_pkg::D_W'($signed({1'b0, pix_sel, 8'h00})
		- $signed({1'b0, mean_rd_q}));

	// pixel capture, difference shift lines and term rotation
	always_ff @(posedge clk) begin
		if (req_fire && req.req_type == mpc_pkg::REQ_CLASSIFY) begin
			red_q   <= req.red;
			green_q <= req.green;
			blue_q  <= req.blue;
		end
		if (state_q == S_MEAN && k_q != 2'd0) begin
			di_q[0] <= di_q[1];
			di_q[1] <= di_q[2];
			di_q[2] <= d_new;
			dj_q[0] <= dj_q[1];
			dj_q[1] <= dj_q[2];
			dj_q[2] <= d_new;
		end else if (state_q == S_TERM && ph_q == PH_HI) begin
			dj_q[0] <= dj_q[1];
			dj_q[1] <= dj_q[2];
			dj_q[2] <= dj_q[0];
			if (j_q == 2'd2) begin
				di_q[0] <= di_q[1];
				di_q[1] <= di_q[2];
				di_q[2] <= di_q[0];
			end
		end
		if (state_q == S_TERM && ph_q == PH_LO) begin
			q_q <= prod[mpc_pkg::Q_W-1:0];
		end
	end

	// multiply-accumulate control
	always_comb begin
		mac_ctrl.mul_en  = (state_q == S_TERM);
		mac_ctrl.acc_clr = (state_q == S_MEAN) && (k_q == 2'd0);
		mac_ctrl.lo_next = (state_q == S_TERM) && (ph_q == PH_LO);
		mac_ctrl.hi_next = (state_q == S_TERM) && (ph_q == PH_HI);
	end

	// operand select: d_i*d_j, then q times low and high coefficient halves
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (ph_q)
			PH_DD: begin
				mul_a = mpc_pkg::MUL_A_W'(di_q[0]);
				mul_b = mpc_pkg::MUL_B_W'(dj_q[0]);
			end
			PH_LO: begin
				mul_a = $signed(prod[mpc_pkg::MUL_A_W-1:0]);
				mul_b = $signed({1'b0, cov_rd_q[mpc_pkg::HI_SHIFT-1:0]});
			end
			default: begin
				mul_a = mpc_pkg::MUL_A_W'(q_q);
				mul_b = mpc_pkg::MUL_B_W'($signed(cov_rd_q[mpc_pkg::PVAL_W-1:mpc_pkg::HI_SHIFT]));
			end
		endcase
	end

	mpc_mac u_mac (
		.clk    (clk),
		.arst_n (arst_n),
		.ctrl   (mac_ctrl),
		.a      (mul_a),
		.b      (mul_b),
		.prod   (prod),
		.acc    (acc)
	);

	// smallest quadratic form wins, lowest index on a tie
	always_ff @(posedge clk) begin
		if (state_q == S_CMP && (class_q == '0 || acc < best_q)) begin
			best_q     <= acc;
			best_idx_q <= class_q;
		end
	end

	// result register
	always_ff @(posedge clk) begin
		if (state_q == S_OUT && out_free) begin
			out_red_q   <= red_q;
			out_green_q <= green_q;
			out_blue_q  <= blue_q;
			label_q     <= mpc_pkg::LABEL_W'(best_idx_q);
		end
	end

	assign res.valid       = res_valid_q;
	assign res.out_red     = out_red_q;
	assign res.out_green   = out_green_q;
	assign res.out_blue    = out_blue_q;
	assign res.class_label = label_q;

	// a result appears only from the output state
	a_res_from_out: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(res_valid_q) |-> $past(state_q == S_OUT))
		else $error("result raised outside the output state");

	// class walk stays inside the class count
	a_class_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != S_IDLE) |-> (class_q < count_q))
		else $error("class index beyond class count");

	// class count saturated to a valid range
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != S_IDLE) |-> (count_q != '0 && 32'(count_q) <= 32'(MAX_CLASSES)))
		else $error("class count out of range");

	// the final add follows the last high-half product of a class
	a_last_after_term: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_LAST) |-> $past(state_q == S_TERM && ph_q == PH_HI
			&& i_q == 2'd2 && j_q == 2'd2))
		else $error("final add without a completed term sweep");

endmodule

>>> verif/mpc_tb_pkg.sv
`timescale 1ns / 100ps
// label predictor and result scoreboard for the mahalanobis pixel classifier testbench
package mpc_tb_pkg;
	import mpc_pkg::*;

	localparam int TB_CLASSES = 32;
	localparam int TB_MEANS   = 3;
	localparam int TB_COEFS   = 9;

	// one request transfer as driven on the request channel
	typedef struct {
		logic [REQ_TYPE_W-1:0]     req_type;
		logic [CLASS_W-1:0]        class_index;
		logic [PIDX_W-1:0]         param_index;
		logic signed [PVAL_W-1:0]  param_value;
		logic [PIX_W-1:0]          red;
		logic [PIX_W-1:0]          green;
		logic [PIX_W-1:0]          blue;
	} request_t;

	// one classified pixel
	typedef struct {
		logic [PIX_W-1:0]   red;
		logic [PIX_W-1:0]   green;
		logic [PIX_W-1:0]   blue;
		logic [LABEL_W-1:0] label;
	} pixel_label_t;

	class label_tracker;
		logic [MEAN_W-1:0]        mean_word [TB_CLASSES][TB_MEANS];
		logic signed [PVAL_W-1:0] inv_cov [TB_CLASSES][TB_COEFS];
		int unsigned              class_count;
		pixel_label_t             labels_due [$];
		int                       errors;

		function new();
			class_count = 1;
			errors = 0;
		endfunction

		// zero means class 0 alone, anything past the class limit saturates
		function void set_class_count(logic [CFG_W-1:0] count);
			if (count == 0)
				class_count = 1;
			else if (count > TB_CLASSES)
				class_count = TB_CLASSES;
			else
				class_count = count;
		endfunction

		// exact d' * M * d for one class; the smallest value is the best score
		function logic signed [127:0] quad_form(int cls, logic [PIX_W-1:0] r,
			logic [PIX_W-1:0] g, logic [PIX_W-1:0] b);
			int                  diff [TB_MEANS];
			longint              prod;
			logic signed [127:0] acc;
			logic signed [127:0] term_q;
			logic signed [127:0] term_m;
			int                  i;
			int                  j;
			diff[0] = int'(r) * 256 - int'(mean_word[cls][0]);
			diff[1] = int'(g) * 256 - int'(mean_word[cls][1]);
			diff[2] = int'(b) * 256 - int'(mean_word[cls][2]);
			acc = '0;
			for (i = 0; i < TB_MEANS; i++) begin
				for (j = 0; j < TB_MEANS; j++) begin
					prod = longint'(diff[i]) * longint'(diff[j]);
					term_q = prod;
					term_m = inv_cov[cls][i * TB_MEANS + j];
					acc = acc + term_q * term_m;
				end
			end
			return acc;
		endfunction

		// a load updates the parameter copy, a pixel queues its expected label
		function void note_request(request_t rq);
			logic signed [127:0] best_q;
			logic signed [127:0] q;
			int                  best;
			int                  c;
			pixel_label_t        due;
			if (rq.req_type == REQ_LOAD) begin
				if (rq.param_index < PIDX_COV_FIRST)
					mean_word[rq.class_index][rq.param_index] = rq.param_value[MEAN_W-1:0];
				else if (rq.param_index < PIDX_END)
					inv_cov[rq.class_index][rq.param_index - PIDX_COV_FIRST] = rq.param_value;
				return;
			end
			best = 0;
			best_q = quad_form(0, rq.red, rq.green, rq.blue);
			for (c = 1; c < class_count; c++) begin
				q = quad_form(c, rq.red, rq.green, rq.blue);
				// strict compare keeps the lowest index on a tie
				if (q < best_q) begin
					best_q = q;
					best = c;
				end
			end
			due.red = rq.red;
			due.green = rq.green;
			due.blue = rq.blue;
			due.label = LABEL_W'(best);
			labels_due.push_back(due);
		endfunction

		function void compare_field(string field, logic [PIX_W-1:0] want,
			logic [PIX_W-1:0] got);
			if (got !== want) begin
				errors++;
				$display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
			end
		endfunction

		// compare one result transfer with the oldest expected label
		function void check_label(pixel_label_t got);
			pixel_label_t want;
			if (labels_due.size() == 0) begin
				errors++;
				$display("%0t: unexpected result, expected none, actual rgb %0d %0d %0d label %0d",
					$time, got.red, got.green, got.blue, got.label);
				return;
			end
			want = labels_due.pop_front();
			compare_field("out_red", want.red, got.red);
			compare_field("out_green", want.green, got.green);
			compare_field("out_blue", want.blue, got.blue);
			compare_field("class_label", PIX_W'(want.label), PIX_W'(got.label));
		endfunction
	endclass

endpackage

>>> verif/tb_top.sv
`timescale 1ns / 100ps
// top of the mahalanobis pixel classifier testbench: clock, reset, drivers and checking
module tb_top;
	import mpc_pkg::*;
	import mpc_tb_pkg::*;

	localparam int TOTAL_ITEMS  = 1900;
	localparam int PHASES       = 24;
	localparam int DRAIN_CYCLES = 40;
	localparam int BIG_BUDGET   = 10;
	localparam int HOLD_CYCLES  = 400;

	logic clk = 1'b0;
	logic arst_n;

	mpc_req_if req_ch();
	mpc_res_if res_ch();
	mpc_cfg_if cfg_ch();

	label_tracker tracker = new();
	int           hold_request;
	int           items_sent;
	bit           sender_calm;

	mahalanobis_pixel_classifier u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.res    (res_ch),
		.cfg    (cfg_ch)
	);

	// 12 ns clock
	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// run limit
	initial begin
		#(150_000_000);
		$display("status: fail");
		$finish;
	end

	// idle length: mostly none, sometimes short, rarely long
	function automatic int gap_length();
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < 70)
			return 0;
		if (roll < 94)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	function automatic logic signed [PVAL_W-1:0] random_word();
		case ($urandom_range(0, 15))
			0: return {1'b0, {(PVAL_W-1){1'b1}}};
			1: return {1'b1, {(PVAL_W-1){1'b0}}};
			2: return '0;
			3: return '1;
			default: return {8'($urandom()), 32'($urandom())};
		endcase
	endfunction

	// request with every field random; callers override what matters
	function automatic request_t random_request();
		request_t rq;
		rq.req_type = REQ_TYPE_W'($urandom_range(0, 1));
		rq.class_index = CLASS_W'($urandom());
		rq.param_index = PIDX_W'($urandom());
		rq.param_value = random_word();
		rq.red = PIX_W'($urandom());
		rq.green = PIX_W'($urandom());
		rq.blue = PIX_W'($urandom());
		return rq;
	endfunction

	function automatic request_t load_word(int cls, int pidx, logic signed [PVAL_W-1:0] value);
		request_t rq;
		rq = random_request();
		rq.req_type = REQ_LOAD;
		rq.class_index = CLASS_W'(cls);
		rq.param_index = PIDX_W'(pidx);
		rq.param_value = value;
		return rq;
	endfunction

	function automatic request_t make_pixel(int r, int g, int b);
		request_t rq;
		rq = random_request();
		rq.req_type = REQ_CLASSIFY;
		rq.red = PIX_W'(r);
		rq.green = PIX_W'(g);
		rq.blue = PIX_W'(b);
		return rq;
	endfunction

	// offer one request, wait for its transfer, then maybe idle
	task automatic send_request(input request_t rq);
		int gap;
		@(negedge clk);
		req_ch.valid <= 1'b1;
		req_ch.req_type <= rq.req_type;
		req_ch.class_index <= rq.class_index;
		req_ch.param_index <= rq.param_index;
		req_ch.param_value <= rq.param_value;
		req_ch.red <= rq.red;
		req_ch.green <= rq.green;
		req_ch.blue <= rq.blue;
		do
			@(posedge clk);
		while (req_ch.ready !== 1'b1);
		tracker.note_request(rq);
		if (!(rq.req_type == REQ_LOAD && rq.param_index >= PIDX_END))
			items_sent++;
		gap = sender_calm ? 0 : gap_length();
		if (gap > 0) begin
			@(negedge clk);
			req_ch.valid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
	endtask

	// stop offering and wait for every pending pixel to come back
	task automatic drain_results();
		@(negedge clk);
		req_ch.valid <= 1'b0;
		while (tracker.labels_due.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// class count write, only with the block idle
	task automatic write_class_count(input logic [CFG_W-1:0] count);
		drain_results();
		@(negedge clk);
		cfg_ch.valid <= 1'b1;
		cfg_ch.num_classes <= count;
		do
			@(posedge clk);
		while (cfg_ch.ready !== 1'b1);
		tracker.set_class_count(count);
		@(negedge clk);
		cfg_ch.valid <= 1'b0;
	endtask

	// result receiver: random stalls, steady stretches and the long hold-off
	initial begin
		int stall_left;
		int steady_left;
		stall_left = 0;
		steady_left = 0;
		res_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_request > 0) begin
				stall_left = hold_request;
				hold_request = 0;
			end else if (stall_left == 0) begin
				if (steady_left > 0)
					steady_left--;
				else if ($urandom_range(0, 99) < 3)
					steady_left = $urandom_range(50, 300);
				else if ($urandom_range(0, 99) < 30)
					stall_left = gap_length();
			end
			if (stall_left > 0) begin
				res_ch.ready <= 1'b0;
				stall_left--;
			end else begin
				res_ch.ready <= 1'b1;
			end
		end
	end

	// check every result transfer
	always @(posedge clk) begin
		if (res_ch.valid === 1'b1 && res_ch.ready === 1'b1)
			tracker.check_label('{res_ch.out_red, res_ch.out_green, res_ch.out_blue,
				res_ch.class_label});
	end

	// stimulus
	initial begin
		int                       phase;
		int                       count;
		int                       budget;
		int                       start;
		int                       roll;
		int                       cls;
		int                       src;
		int                       dst;
		int                       p;
		logic signed [PVAL_W-1:0] value;
		arst_n = 1'b0;
		req_ch.valid = 1'b0;
		req_ch.req_type = REQ_LOAD;
		req_ch.class_index = '0;
		req_ch.param_index = '0;
		req_ch.param_value = '0;
		req_ch.red = '0;
		req_ch.green = '0;
		req_ch.blue = '0;
		cfg_ch.valid = 1'b0;
		cfg_ch.num_classes = '0;
		hold_request = 0;
		items_sent = 0;
		sender_calm = 1'b0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// every class fully written before any pixel reads it
		for (cls = 0; cls < TB_CLASSES; cls++)
			for (p = 0; p < PIDX_END; p++)
				send_request(load_word(cls, p, random_word()));

		// both classes centered on mid gray: an exact tie goes to class 0
		write_class_count(CFG_W'(2));
		for (p = 0; p < PIDX_COV_FIRST; p++) begin
			send_request(load_word(0, p, 40'hFF_FFFF_8000));
			send_request(load_word(1, p, 40'h00_0000_8000));
		end
		send_request(make_pixel(128, 128, 128));
		// extreme coefficients and extreme pixels
		send_request(load_word(0, PIDX_COV_FIRST, {1'b0, {(PVAL_W-1){1'b1}}}));
		send_request(load_word(1, PIDX_END - 1, {1'b1, {(PVAL_W-1){1'b0}}}));
		send_request(make_pixel(0, 0, 0));
		send_request(make_pixel(255, 255, 255));
		send_request(make_pixel(255, 0, 255));
		// words past the matrix are dropped, then a mean word of class 31 is rewritten
		send_request(load_word(31, PIDX_END, '1));
		send_request(load_word(31, 15, '1));
		send_request(load_word(31, 0, 40'h00_0000_FFFF));
		// zero count evaluates class 0 alone
		write_class_count(CFG_W'(0));
		send_request(make_pixel(17, 200, 3));
		// count above the class limit saturates
		write_class_count(CFG_W'(63));
		send_request(make_pixel(0, 255, 0));
		send_request(make_pixel(255, 255, 255));
		write_class_count(CFG_W'(32));
		send_request(make_pixel(1, 254, 127));

		// random phases, each with its own class count
		for (phase = 0; phase < PHASES; phase++) begin
			case (phase)
				2: count = 2;
				4: count = 32;
				10: count = 63;
				16: count = 0;
				20: count = 33;
				default: count = ($urandom_range(0, 3) == 0) ? $urandom_range(5, 12) :
					$urandom_range(1, 4);
			endcase
			write_class_count(CFG_W'(count));
			if (tracker.class_count >= TB_CLASSES)
				budget = BIG_BUDGET;
			else
				budget = (TOTAL_ITEMS - items_sent) / (PHASES - phase);
			sender_calm = (phase == 2) || ($urandom_range(0, 3) == 0);
			// receiver holds off while the sender keeps offering
			if (phase == 2)
				hold_request = HOLD_CYCLES;
			start = items_sent;
			while (items_sent - start < budget) begin
				roll = $urandom_range(0, 99);
				if (roll < 40) begin
					send_request(make_pixel($urandom_range(0, 255), $urandom_range(0, 255),
						$urandom_range(0, 255)));
				end else if (roll < 55) begin
					// pixel at or near a class center
					cls = $urandom_range(0, tracker.class_count - 1);
					send_request(make_pixel(tracker.mean_word[cls][0][MEAN_W-1:8],
						tracker.mean_word[cls][1][MEAN_W-1:8] ^ $urandom_range(0, 1),
						tracker.mean_word[cls][2][MEAN_W-1:8]));
				end else if (roll < 62) begin
					// copy one class onto another to force ties
					src = $urandom_range(0, tracker.class_count - 1);
					dst = $urandom_range(0, tracker.class_count - 1);
					for (p = 0; p < PIDX_END; p++) begin
						if (p < PIDX_COV_FIRST)
							value = {24'($urandom()), tracker.mean_word[src][p]};
						else
							value = tracker.inv_cov[src][p - PIDX_COV_FIRST];
						send_request(load_word(dst, p, value));
					end
				end else if (roll < 66) begin
					send_request(load_word($urandom_range(0, 31), $urandom_range(12, 15),
						random_word()));
				end else begin
					send_request(load_word($urandom_range(0, 31), $urandom_range(0, 11),
						random_word()));
				end
			end
		end

		drain_results();
		if (tracker.errors == 0 && tracker.labels_due.size() == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule

>>> files.f
hw/rtl/mpc_pkg.sv
hw/rtl/mpc_ifs.sv
hw/rtl/mpc_mac.sv
hw/rtl/mahalanobis_pixel_classifier.sv
verif/mpc_tb_pkg.sv
verif/tb_top.sv
